// ----- design/ihp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ihp_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 32;
    localparam int ID_BITS   = 10;
    localparam int ID_SPACE  = 1 << ID_BITS;
    localparam int SLOT_BITS = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int STAT_BITS = 2;

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [ID_BITS-1:0]   id_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

endpackage

`default_nettype wire

// ----- design/ihp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ihp_in_if;
    logic          valid;
    logic          ready;
    logic          action;
    ihp_pkg::id_t  item_id;
    ihp_pkg::key_t key_in;

    modport source (output valid, action, item_id, key_in, input ready);
    modport sink   (input valid, action, item_id, key_in, output ready);
endinterface

`default_nettype wire

// ----- design/ihp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ihp_out_if;
    logic                              valid;
    logic                              ready;
    ihp_pkg::id_t                      out_id;
    ihp_pkg::key_t                     out_key;
    logic [ihp_pkg::STAT_BITS-1:0]     status;
    logic [ihp_pkg::SLOT_BITS-1:0]     occupancy;

    modport source (output valid, out_id, out_key, status, occupancy, input ready);
    modport sink   (input valid, out_id, out_key, status, occupancy, output ready);
endinterface

`default_nettype wire

// ----- design/indexed_min_heap.sv -----
// Indexed binary min-heap with decrease-key, for shortest-path searches.
// The req channel carries one request per transfer: action 0 inserts item_id
// with key_in, or lowers the key of an id already held; action 1 pops the id
// with the least key. Every request yields exactly one transfer on the rsp
// channel with the popped id and key (zero otherwise), a status code and the
// occupancy after the request.
// One request is in work at a time. Each heap level on the way up passes
// S_UP_READ, S_UP_HEAP and S_UP_KEY, and on the way down S_DN_CHK, S_DN_A
// and S_DN_AK, plus S_DN_BK when a right child has to be compared, as each
// level needs dependent reads of the slot memory and then the key memory.
// After reset the position table is swept to zero, one entry a cycle, over
// all 1024 entries; req.ready stays low during that sweep.
// When the receiver stalls, the finished response waits in the output
// register. The next request is still taken and worked on, but its response
// is held back, and no further request is taken, until the register empties.
`timescale 1ns / 1ps
`default_nettype none

module indexed_min_heap (
    input  wire        clk,
    input  wire        rst_n,
    ihp_in_if.sink     req,
    ihp_out_if.source  rsp
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INS_POS, S_INS_KEY, S_UP_READ, S_UP_HEAP, S_UP_KEY,
        S_POP_TOP, S_POP_LAST, S_POP_LK, S_DN_CHK, S_DN_A, S_DN_AK, S_DN_BK,
        S_POP_CLR, S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic                    act_reg, act_next;
    ihp_pkg::id_t            id_reg, id_next;
    ihp_pkg::key_t           key_reg, key_next;
    ihp_pkg::slot_t          cur_reg, cur_next;
    ihp_pkg::slot_t          cnt_reg, cnt_next;
    ihp_pkg::id_t            top_reg, top_next;
    ihp_pkg::key_t           topkey_reg, topkey_next;
    ihp_pkg::id_t            last_reg, last_next;
    ihp_pkg::id_t            a_reg, a_next;
    ihp_pkg::key_t           ka_reg, ka_next;
    ihp_pkg::addr_t          clr_reg, clr_next;
    ihp_pkg::status_t        status_reg, status_next;

    logic                    out_valid_reg;
    ihp_pkg::id_t            out_id_reg;
    ihp_pkg::key_t           out_key_reg;
    ihp_pkg::status_t        out_status_reg;
    ihp_pkg::slot_t          out_occ_reg;

    // Memories: keys per id, ids per slot (slot s at index s-1), slot per id.
    ihp_pkg::key_t           key_mem  [ihp_pkg::ID_SPACE];
    ihp_pkg::id_t            heap_mem [ihp_pkg::CAPACITY];
    ihp_pkg::slot_t          pos_mem  [ihp_pkg::ID_SPACE];

    logic                    key_we, heap_we, pos_we;
    ihp_pkg::id_t            key_waddr, key_raddr, pos_waddr, pos_raddr;
    ihp_pkg::addr_t          heap_waddr, heap_raddr;
    ihp_pkg::key_t           key_wdata, key_rdata;
    ihp_pkg::id_t            heap_wdata, heap_rdata;
    ihp_pkg::slot_t          pos_wdata, pos_rdata;

    logic [ihp_pkg::SLOT_BITS:0] child2;
    logic [ihp_pkg::SLOT_BITS:0] child2_m1;
    ihp_pkg::slot_t              parent;
    ihp_pkg::slot_t              cur_m1;
    logic                        has_right;
    logic                        take_right;
    ihp_pkg::id_t                pick_id;
    ihp_pkg::key_t               pick_key;
    ihp_pkg::slot_t              pick_slot;
    logic                        load_out;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rdata <= heap_mem[heap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rdata <= pos_mem[pos_raddr];
    end

    assign child2    = {cur_reg, 1'b0};
    assign child2_m1 = child2 - 1'b1;
    assign parent    = cur_reg >> 1;
    assign cur_m1    = cur_reg - 1'b1;
    // Whether the left child (slot 2r) has a right sibling within the heap.
    assign has_right = child2 < {1'b0, cnt_reg};
    // The right child wins only on a strictly lower key.
    assign take_right = key_rdata < ka_reg;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        top_next    = top_reg;
        topkey_next = topkey_reg;
        last_next   = last_reg;
        a_next      = a_reg;
        ka_next     = ka_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        key_we      = 1'b0;
        key_waddr   = id_reg;
        key_wdata   = key_reg;
        key_raddr   = id_reg;
        heap_we     = 1'b0;
        heap_waddr  = cur_m1[ihp_pkg::ADDR_BITS-1:0];
        heap_wdata  = id_reg;
        heap_raddr  = '0;
        pos_we      = 1'b0;
        pos_waddr   = id_reg;
        pos_wdata   = cur_reg;
        pos_raddr   = id_reg;
        pick_id     = a_reg;
        pick_key    = ka_reg;
        pick_slot   = child2[ihp_pkg::SLOT_BITS-1:0];

        case (state_reg)
            S_CLR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ihp_pkg::addr_t'(ihp_pkg::ID_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = req.action;
                    id_next     = req.item_id;
                    key_next    = req.key_in;
                    status_next = ihp_pkg::STAT_OK;
                    pos_raddr   = req.item_id;
                    heap_raddr  = '0;
                    if (req.action == ihp_pkg::ACT_INSERT)
                    begin
                        state_next = S_INS_POS;
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = ihp_pkg::STAT_EMPTY;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_POP_TOP;
                    end
                end
            end
            S_INS_POS:
            begin
                if (pos_rdata != '0)
                begin
                    cur_next   = pos_rdata;
                    key_raddr  = id_reg;
                    state_next = S_INS_KEY;
                end
                else if (cnt_reg == ihp_pkg::slot_t'(ihp_pkg::CAPACITY))
                begin
                    status_next = ihp_pkg::STAT_IGNORED;
                    state_next  = S_OUT;
                end
                else
                begin
                    key_we     = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    cur_next   = cnt_reg + 1'b1;
                    state_next = S_UP_READ;
                end
            end
            S_INS_KEY:
            begin
                if (key_reg >= key_rdata)
                begin
                    status_next = ihp_pkg::STAT_IGNORED;
                    state_next  = S_OUT;
                end
                else
                begin
                    key_we     = 1'b1;
                    state_next = S_UP_READ;
                end
            end
            S_UP_READ:
            begin
                if (parent == '0)
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    heap_raddr = ihp_pkg::addr_t'(parent - 1'b1);
                    state_next = S_UP_HEAP;
                end
            end
            S_UP_HEAP:
            begin
                a_next     = heap_rdata;
                key_raddr  = heap_rdata;
                state_next = S_UP_KEY;
            end
            S_UP_KEY:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (key_rdata > key_reg)
                begin
                    // Parent moves down into the current slot.
                    heap_wdata = a_reg;
                    pos_waddr  = a_reg;
                    cur_next   = parent;
                    state_next = S_UP_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_POP_TOP:
            begin
                top_next   = heap_rdata;
                key_raddr  = heap_rdata;
                heap_raddr = ihp_pkg::addr_t'(cnt_reg - 1'b1);
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                topkey_next = key_rdata;
                last_next   = heap_rdata;
                cnt_next    = cnt_reg - 1'b1;
                cur_next    = ihp_pkg::slot_t'(1);
                key_raddr   = heap_rdata;
                if (cnt_reg == ihp_pkg::slot_t'(1))
                begin
                    state_next = S_POP_CLR;
                end
                else
                begin
                    state_next = S_POP_LK;
                end
            end
            S_POP_LK:
            begin
                key_next   = key_rdata;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (child2 > {1'b0, cnt_reg})
                begin
                    heap_we    = 1'b1;
                    heap_wdata = last_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = last_reg;
                    state_next = S_POP_CLR;
                end
                else
                begin
                    heap_raddr = child2_m1[ihp_pkg::ADDR_BITS-1:0];
                    state_next = S_DN_A;
                end
            end
            S_DN_A:
            begin
                a_next     = heap_rdata;
                key_raddr  = heap_rdata;
                heap_raddr = child2[ihp_pkg::ADDR_BITS-1:0];
                state_next = S_DN_AK;
            end
            S_DN_AK:
            begin
                ka_next = key_rdata;
                if (has_right)
                begin
                    last_next  = last_reg;
                    key_raddr  = heap_rdata;
                    top_next   = top_reg;
                    id_next    = heap_rdata;
                    state_next = S_DN_BK;
                end
                else
                begin
                    pick_key = key_rdata;
                    if (key_reg <= pick_key)
                    begin
                        heap_we    = 1'b1;
                        heap_wdata = last_reg;
                        pos_we     = 1'b1;
                        pos_waddr  = last_reg;
                        state_next = S_POP_CLR;
                    end
                    else
                    begin
                        heap_we    = 1'b1;
                        heap_wdata = pick_id;
                        pos_we     = 1'b1;
                        pos_waddr  = pick_id;
                        cur_next   = pick_slot;
                        state_next = S_DN_CHK;
                    end
                end
            end
            S_DN_BK:
            begin
                // id_reg holds the right child's id here, loaded in S_DN_AK.
                if (take_right)
                begin
                    pick_id   = id_reg;
                    pick_key  = key_rdata;
                    pick_slot = ihp_pkg::slot_t'(child2 + 1'b1);
                end
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (key_reg <= pick_key)
                begin
                    heap_wdata = last_reg;
                    pos_waddr  = last_reg;
                    state_next = S_POP_CLR;
                end
                else
                begin
                    heap_wdata = pick_id;
                    pos_waddr  = pick_id;
                    cur_next   = pick_slot;
                    state_next = S_DN_CHK;
                end
            end
            S_POP_CLR:
            begin
                pos_we     = 1'b1;
                pos_waddr  = top_reg;
                pos_wdata  = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            act_reg        <= ihp_pkg::ACT_INSERT;
            id_reg         <= '0;
            key_reg        <= '0;
            cur_reg        <= '0;
            cnt_reg        <= '0;
            top_reg        <= '0;
            topkey_reg     <= '0;
            last_reg       <= '0;
            a_reg          <= '0;
            ka_reg         <= '0;
            clr_reg        <= '0;
            status_reg     <= ihp_pkg::STAT_OK;
            out_valid_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_key_reg    <= '0;
            out_status_reg <= ihp_pkg::STAT_OK;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            id_reg     <= id_next;
            key_reg    <= key_next;
            cur_reg    <= cur_next;
            cnt_reg    <= cnt_next;
            top_reg    <= top_next;
            topkey_reg <= topkey_next;
            last_reg   <= last_next;
            a_reg      <= a_next;
            ka_reg     <= ka_next;
            clr_reg    <= clr_next;
            status_reg <= status_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if ((act_reg == ihp_pkg::ACT_POP) && (status_reg == ihp_pkg::STAT_OK))
                begin
                    out_id_reg  <= top_reg;
                    out_key_reg <= topkey_reg;
                end
                else
                begin
                    out_id_reg  <= '0;
                    out_key_reg <= '0;
                end
                out_status_reg <= status_reg;
                out_occ_reg    <= cnt_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_id    = out_id_reg;
    assign rsp.out_key   = out_key_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.occupancy = out_occ_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ihp_pkg::slot_t'(ihp_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in work");

    a_heap_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        heap_we |-> ({1'b0, heap_waddr} < cnt_reg))
        else $error("heap slot written beyond the entry count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ihp_pkg::STAT_EMPTY) |-> (rsp.out_id == '0))
        else $error("empty pop carries an id");
`endif

endmodule

`default_nettype wire
